/* rtl/bfpc_pkg.sv */
`default_nettype none
package bfpc_pkg;

  localparam int unsigned NumSamples = 24;
  localparam int unsigned MemDepth   = 2 * NumSamples;
  localparam int unsigned MemAw      = $clog2(MemDepth);
  localparam int unsigned CntW       = $clog2(NumSamples);
  localparam int unsigned SampleW    = 16;
  localparam int unsigned MagW       = SampleW - 1;
  localparam int unsigned WidthW     = 5;
  localparam int unsigned ExpW       = 4;
  localparam int unsigned AccW       = 24;
  localparam int unsigned NbitW      = 5;
  localparam int unsigned LeftW      = 6;

  localparam logic [WidthW-1:0] WidthReset = 5'd9;
  localparam logic [WidthW-1:0] WidthMin   = 5'd1;
  localparam logic [WidthW-1:0] WidthMax   = 5'd16;

  localparam logic [SampleW-1:0] MinSample = 16'h8000;
  localparam logic [MagW-1:0]    MaxMag    = 15'h7fff;

  typedef struct packed {
    logic              bank;
    logic [MagW-1:0]   peak;
    logic [WidthW-1:0] width;
    logic              burst;
  } desc_t;

  function automatic logic [4:0] lzc16(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 5'(15 - i);
    end
    return n;
  endfunction

  function automatic logic [MemAw-1:0] mem_addr(input logic bank, input logic [CntW-1:0] idx);
    logic [MemAw-1:0] base;
    base = bank ? MemAw'(NumSamples) : '0;
    return base + MemAw'(idx);
  endfunction

endpackage
`default_nettype wire

/* rtl/bfpc_store.sv */
`default_nettype none
module bfpc_store (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [bfpc_pkg::MemAw-1:0]   wr_addr_i,
  input  wire logic [bfpc_pkg::SampleW-1:0] wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [bfpc_pkg::MemAw-1:0]   rd_addr_i,
  output logic      [bfpc_pkg::SampleW-1:0] rd_data_o
);

  logic [bfpc_pkg::SampleW-1:0] mem_q [bfpc_pkg::MemDepth];
  logic [bfpc_pkg::SampleW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/bfpc_queue.sv */
`default_nettype none
module bfpc_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire bfpc_pkg::desc_t push_desc_i,
  input  wire logic            pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output bfpc_pkg::desc_t      head_o
);

  bfpc_pkg::desc_t ent_q [2];
  logic            wptr_q, wptr_d;
  logic            rptr_q, rptr_d;
  logic [1:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = ent_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= push_desc_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/bfpc_front.sv */
`default_nettype none
module bfpc_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_valid_i,
  output logic                             s_ready_o,
  input  wire logic [bfpc_pkg::SampleW-1:0] sample_i,
  input  wire logic                        final_i,
  input  wire logic [bfpc_pkg::WidthW-1:0]  width_i,
  input  wire logic                        q_full_i,
  output logic                             wr_en_o,
  output logic      [bfpc_pkg::MemAw-1:0]   wr_addr_o,
  output logic      [bfpc_pkg::SampleW-1:0] wr_data_o,
  output logic                             push_o,
  output bfpc_pkg::desc_t                  push_desc_o
);

  logic [bfpc_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [bfpc_pkg::MagW-1:0]    max_q, max_d;
  logic                         bank_q, bank_d;
  logic                         accept;
  logic                         last;
  logic [bfpc_pkg::SampleW-1:0] neg;
  logic [bfpc_pkg::MagW-1:0]    mag;
  logic [bfpc_pkg::MagW-1:0]    peak;
  logic [bfpc_pkg::WidthW-1:0]  wcl;

  assign s_ready_o = ~q_full_i;
  assign accept    = s_valid_i & ~q_full_i;
  assign last      = (cnt_q == bfpc_pkg::CntW'(bfpc_pkg::NumSamples - 1));
  assign neg       = ~sample_i + 16'd1;

  always_comb begin
    if (sample_i == bfpc_pkg::MinSample) begin
      mag = bfpc_pkg::MaxMag;
    end else if (sample_i[bfpc_pkg::SampleW-1]) begin
      mag = neg[bfpc_pkg::MagW-1:0];
    end else begin
      mag = sample_i[bfpc_pkg::MagW-1:0];
    end
    peak = (mag > max_q) ? mag : max_q;
    if (width_i < bfpc_pkg::WidthMin) begin
      wcl = bfpc_pkg::WidthMin;
    end else if (width_i > bfpc_pkg::WidthMax) begin
      wcl = bfpc_pkg::WidthMax;
    end else begin
      wcl = width_i;
    end
  end

  assign wr_en_o   = accept;
  assign wr_addr_o = bfpc_pkg::mem_addr(bank_q, cnt_q);
  assign wr_data_o = sample_i;
  assign push_o    = accept & last;

  always_comb begin
    push_desc_o.bank  = bank_q;
    push_desc_o.peak  = peak;
    push_desc_o.width = wcl;
    push_desc_o.burst = final_i;
  end

  always_comb begin
    cnt_d  = cnt_q;
    max_d  = max_q;
    bank_d = bank_q;
    if (accept) begin
      if (last) begin
        cnt_d  = '0;
        max_d  = '0;
        bank_d = ~bank_q;
      end else begin
        cnt_d = cnt_q + bfpc_pkg::CntW'(1);
        max_d = peak;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      max_q  <= '0;
      bank_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      max_q  <= max_d;
      bank_q <= bank_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/bfpc_back.sv */
`default_nettype none
module bfpc_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_valid_i,
  input  wire bfpc_pkg::desc_t             q_desc_i,
  output logic                             pop_o,
  output logic                             rd_en_o,
  output logic      [bfpc_pkg::MemAw-1:0]   rd_addr_o,
  input  wire logic [bfpc_pkg::SampleW-1:0] rd_data_i,
  output logic                             m_valid_o,
  input  wire logic                        m_ready_i,
  output logic      [7:0]                  m_data_o,
  output logic                             m_last_o,
  output logic                             m_user_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StExp  = 3'b010,
    StPay  = 3'b100
  } back_state_e;

  back_state_e                  st_q, st_d;
  logic [bfpc_pkg::ExpW-1:0]    e_q, e_d;
  logic [bfpc_pkg::WidthW-1:0]  w_q, w_d;
  logic                         bank_q, bank_d;
  logic                         burst_q, burst_d;
  logic [bfpc_pkg::LeftW-1:0]   left_q, left_d;
  logic [bfpc_pkg::CntW-1:0]    rcnt_q, rcnt_d;
  logic                         rv_q, rv_d;
  logic [bfpc_pkg::AccW-1:0]    acc_q, acc_d;
  logic [bfpc_pkg::NbitW-1:0]   nbits_q, nbits_d;
  logic                         ov_q, ov_d;
  logic [7:0]                   od_q, od_d;
  logic                         ol_q, ol_d;
  logic                         ou_q, ou_d;

  logic                         ld;
  logic                         emit_pay;
  logic                         consume;
  logic                         issue;
  logic [5:0]                   avail;
  logic [5:0]                   sum;
  logic [bfpc_pkg::ExpW-1:0]    e_new;
  logic [bfpc_pkg::SampleW-1:0] shifted;
  logic [bfpc_pkg::SampleW-1:0] mask;
  logic [bfpc_pkg::SampleW-1:0] p;
  logic [7:0]                   byte_out;

  assign ld       = ~ov_q | m_ready_i;
  assign emit_pay = (st_q == StPay) && ld && (nbits_q >= 5'd8);
  assign avail    = {1'b0, nbits_q} - (emit_pay ? 6'd8 : 6'd0);
  assign consume  = rv_q && (st_q != StIdle) &&
                    ((avail + {1'b0, w_q}) <= 6'(bfpc_pkg::AccW));
  assign issue    = (st_q != StIdle) &&
                    (rcnt_q < bfpc_pkg::CntW'(bfpc_pkg::NumSamples)) && (!rv_q || consume);

  assign rd_en_o   = issue;
  assign rd_addr_o = bfpc_pkg::mem_addr(bank_q, rcnt_q);

  assign sum     = 6'(q_desc_i.width) + 6'(bfpc_pkg::lzc16({1'b0, q_desc_i.peak}));
  assign e_new   = (sum >= 6'd17) ? '0 : 4'(6'd17 - sum);
  assign shifted = 16'($signed(rd_data_i) >>> e_q);
  assign mask    = 16'((17'd1 << w_q) - 17'd1);
  assign p       = shifted & mask;
  assign byte_out = 8'(acc_q >> (nbits_q - 5'd8));

  assign m_valid_o = ov_q;
  assign m_data_o  = od_q;
  assign m_last_o  = ol_q;
  assign m_user_o  = ou_q;

  always_comb begin
    st_d    = st_q;
    e_d     = e_q;
    w_d     = w_q;
    bank_d  = bank_q;
    burst_d = burst_q;
    left_d  = left_q;
    rcnt_d  = rcnt_q;
    rv_d    = rv_q;
    acc_d   = acc_q;
    nbits_d = 5'(avail);
    ov_d    = ov_q;
    od_d    = od_q;
    ol_d    = ol_q;
    ou_d    = ou_q;
    pop_o   = 1'b0;

    if (ld) begin
      ov_d = 1'b0;
    end
    if (issue) begin
      rv_d   = 1'b1;
      rcnt_d = rcnt_q + bfpc_pkg::CntW'(1);
    end else if (consume) begin
      rv_d = 1'b0;
    end
    if (consume) begin
      acc_d   = (acc_q << w_q) | bfpc_pkg::AccW'(p);
      nbits_d = 5'(avail + 6'(w_q));
    end

    case (st_q)
      StIdle: begin
        if (q_valid_i) begin
          e_d     = e_new;
          w_d     = q_desc_i.width;
          bank_d  = q_desc_i.bank;
          burst_d = q_desc_i.burst;
          left_d  = 6'(q_desc_i.width) * 6'd3;
          rcnt_d  = '0;
          st_d    = StExp;
        end
      end
      StExp: begin
        if (ld) begin
          ov_d = 1'b1;
          od_d = 8'(e_q);
          ol_d = 1'b0;
          ou_d = 1'b0;
          st_d = StPay;
        end
      end
      StPay: begin
        if (emit_pay) begin
          ov_d   = 1'b1;
          od_d   = byte_out;
          left_d = left_q - 6'd1;
          if (left_q == 6'd1) begin
            ol_d  = 1'b1;
            ou_d  = burst_q;
            pop_o = 1'b1;
            st_d  = StIdle;
          end else begin
            ol_d = 1'b0;
            ou_d = 1'b0;
          end
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      rcnt_q  <= '0;
      rv_q    <= 1'b0;
      nbits_q <= '0;
      left_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      rcnt_q  <= rcnt_d;
      rv_q    <= rv_d;
      nbits_q <= nbits_d;
      left_q  <= left_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q     <= e_d;
    w_q     <= w_d;
    bank_q  <= bank_d;
    burst_q <= burst_d;
    acc_q   <= acc_d;
    od_q    <= od_d;
    ol_q    <= ol_d;
    ou_q    <= ou_d;
  end

endmodule
`default_nettype wire

/* rtl/bfp_block_compressor_top.sv */
// Block floating point compressor.
// Input stream: s_axis_tdata carries one signed 16-bit sample, s_axis_tuser
// the final-block flag; 24 samples make one block. Samples go into a two-bank
// sample store, so the next block can be taken while the previous one drains.
// Output stream: per block one exponent byte, then 3*width payload bytes,
// samples shifted right by the exponent, cut to width bits, packed MSB first.
// m_axis_tlast marks a block's last byte, m_axis_tuser its last byte when the
// completing sample carried the final-block flag.
// The completing sample is pushed into the descriptor queue, the drain unit
// moves from idle to the exponent state, and the output register then takes
// the exponent byte. Throughput: one sample per cycle into a free bank; the
// drain unit reads at most one sample and sends at most one byte per cycle,
// holding both while its accumulator lacks room or m_axis_tready is low. With
// both banks full s_axis_tready stays low.
// Config: APB register sample_width at addresses 0 to 3 (reset 9; 0 acts as 1,
// above 16 as 16), sampled when a block completes.
// Reset clears the counters, the state and the valid flags; the output byte,
// its last and user flags and the sample store are not cleared. A stall on
// m_axis_tready holds the output byte and backs up through the banks to s_axis_tready.
`default_nettype none
module bfp_block_compressor_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
  input  wire logic [0:0]  s_axis_tuser,   // [0] final_block
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [7:0]  m_axis_tdata,   // [7:0] comp_byte
  output logic             m_axis_tlast,
  output logic      [0:0]  m_axis_tuser,   // [0] burst_last
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [bfpc_pkg::WidthW-1:0]  sw_q, sw_d;
  logic                         wr_en;
  logic [bfpc_pkg::MemAw-1:0]   wr_addr;
  logic [bfpc_pkg::SampleW-1:0] wr_data;
  logic                         rd_en;
  logic [bfpc_pkg::MemAw-1:0]   rd_addr;
  logic [bfpc_pkg::SampleW-1:0] rd_data;
  logic                         push;
  bfpc_pkg::desc_t              push_desc;
  logic                         pop;
  logic                         q_full;
  logic                         q_valid;
  bfpc_pkg::desc_t              q_head;

  assign pready = 1'b1;
  assign prdata = 32'(sw_q);

  always_comb begin
    sw_d = sw_q;
    if (psel && penable && pwrite && pready && !paddr[2]) begin
      sw_d = pwdata[bfpc_pkg::WidthW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= bfpc_pkg::WidthReset;
    end else begin
      sw_q <= sw_d;
    end
  end

  bfpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .sample_i    (s_axis_tdata),
    .final_i     (s_axis_tuser[0]),
    .width_i     (sw_q),
    .q_full_i    (q_full),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  bfpc_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bfpc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  bfpc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_desc_i  (q_head),
    .pop_o     (pop),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast),
    .m_user_o  (m_axis_tuser[0])
  );

endmodule
`default_nettype wire

/* rtl/bfpc_checker.sv */
`default_nettype none
module bfpc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic [0:0]  m_axis_tuser,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  a_burst_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("burst end flagged on a byte that does not end a block");

  a_exp_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
    !m_axis_tvalid || !m_axis_tlast)
    else $error("block of a single byte");

  a_width_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready && prdata[31:5] == 27'd0)
    else $error("config readback out of range");

endmodule

bind bfp_block_compressor_top bfpc_checker u_bfpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser),
  .prdata        (prdata),
  .pready        (pready)
);
`default_nettype wire
